// ----- rtl/npcs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_pkg
// Shared types and constants for the nearest palette color search block.
// ----------------------------------------------------------------------------
package npcs_pkg;

    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);
    localparam int CNT_W     = $clog2(PAL_DEPTH + 1);
    localparam int DIST_W    = 18;
    localparam int SQ_W      = 16;

    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
    // largest reachable distance: three full-scale squared differences
    localparam logic [DIST_W-1:0] DIST_REACH = DIST_W'(3 * 255 * 255);

    // apb register map, by word index
    localparam logic [1:0] REG_PALETTE_COUNT = 2'd0;
    localparam logic [1:0] REG_SKIP_ENABLE   = 2'd1;
    localparam logic [1:0] REG_SKIP_INDEX    = 2'd2;

    // input kind carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic [PAL_AW-1:0] index;
    } tag_t;

    typedef struct packed {
        tag_t              tag;
        logic [DIST_W-1:0] distance;
        rgb_t              color;
    } cand_t;

endpackage : npcs_pkg
`default_nettype wire

// ----- rtl/npcs_pal_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_pal_ram
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module npcs_pal_ram (
    input  wire logic                      aclk,
    input  wire logic                      we,
    input  wire logic [npcs_pkg::PAL_AW-1:0] waddr,
    input  wire npcs_pkg::rgb_t            wdata,
    input  wire logic [npcs_pkg::PAL_AW-1:0] raddr,
    output npcs_pkg::rgb_t                 rdata
);
    import npcs_pkg::*;

    rgb_t mem [PAL_DEPTH];
    rgb_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule : npcs_pal_ram
`default_nettype wire

// ----- rtl/npcs_dist_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npcs_dist_unit
// Two-stage squared distance unit, shared by every entry of a scan.
// ----------------------------------------------------------------------------
module npcs_dist_unit (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire npcs_pkg::rgb_t query,
    input  wire npcs_pkg::rgb_t entry,
    input  wire npcs_pkg::tag_t tag_in,
    output npcs_pkg::cand_t     cand_out
);
    import npcs_pkg::*;

    function automatic logic [SQ_W-1:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    tag_t             tag1_reg, tag1_next;
    rgb_t             color1_reg;
    logic [SQ_W-1:0]  sq_r_reg, sq_g_reg, sq_b_reg;
    cand_t            cand_reg, cand_next;

    always_comb begin
        tag1_next          = tag_in;
        cand_next.tag      = tag1_reg;
        cand_next.color    = color1_reg;
        cand_next.distance = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg       <= '0;
            cand_reg.tag   <= '0;
        end else begin
            tag1_reg       <= tag1_next;
            cand_reg.tag   <= cand_next.tag;
        end
        color1_reg        <= entry;
        sq_r_reg          <= sq_diff(query.red, entry.red);
        sq_g_reg          <= sq_diff(query.green, entry.green);
        sq_b_reg          <= sq_diff(query.blue, entry.blue);
        cand_reg.distance <= cand_next.distance;
        cand_reg.color    <= cand_next.color;
    end

    assign cand_out = cand_reg;

endmodule : npcs_dist_unit
`default_nettype wire

// ----- rtl/nearest_palette_color_search.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_search
// Palette of rgb entries with a sequential least-squares nearest color search.
// ----------------------------------------------------------------------------
//  channel  dir  handshake         contents
//  s_       in   s_tvalid/tready   tuser op, tdata entry_index red green blue
//  m_       out  m_tvalid/tready   tuser found, tdata index color distance
//  apb      in   psel/penable      palette_count, skip_enable, skip_index
//
//  a write request is taken while idle; a query scans one palette entry per cycle
//  through the memory read port, count = min(palette_count, 256) entries, and
//  goes straight to done when count is zero; each entry passes the memory read
//  register and the two-stage distance unit before it is compared.
//  s_tready is low for the whole scan; a finished result waits in the output
//  register while the next request is taken. sync active-low reset, no
//  clearing pass: the palette is undefined until written.
// ----------------------------------------------------------------------------
module nearest_palette_color_search (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // entry_index, red, green, blue
    input  wire logic        s_tuser,   // op
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // best_index, match_red, match_green,
                                        // match_blue, distance, zero pad
    output logic             m_tuser,   // found
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import npcs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [8:0]         pal_count_reg;
    logic               skip_en_reg;
    logic [7:0]         skip_idx_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   scan_idx_reg, scan_idx_next;
    rgb_t               query_reg;
    tag_t               tag_reg, tag_next;
    logic               found_reg, found_next;
    logic [DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic [PAL_AW-1:0]  best_idx_reg, best_idx_next;
    rgb_t               best_color_reg, best_color_next;
    logic               m_valid_reg, m_valid_next;
    logic [55:0]        m_data_reg, m_data_next;
    logic               m_found_reg, m_found_next;

    logic               s_accept, cfg_write, ram_we, out_free;
    logic [CNT_W-1:0]   count_eff;
    rgb_t               s_color, ram_rdata;
    cand_t              cand;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_count_reg <= 9'd256;
            skip_en_reg   <= 1'b0;
            skip_idx_reg  <= 8'd0;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_PALETTE_COUNT: pal_count_reg <= pwdata[8:0];
                REG_SKIP_ENABLE:   skip_en_reg   <= pwdata[0];
                REG_SKIP_INDEX:    skip_idx_reg  <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PALETTE_COUNT: prdata = 32'(pal_count_reg);
            REG_SKIP_ENABLE:   prdata = 32'(skip_en_reg);
            REG_SKIP_INDEX:    prdata = 32'(skip_idx_reg);
            default:           prdata = 32'd0;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign s_color  = rgb_t'(s_tdata[31:8]);
    assign ram_we   = s_accept && (s_tuser == OP_WRITE) && (32'(s_tdata[7:0]) < PAL_DEPTH);
    assign count_eff = (32'(pal_count_reg) > PAL_DEPTH) ? CNT_W'(PAL_DEPTH)
                                                        : CNT_W'(pal_count_reg);
    assign out_free = !m_valid_reg || m_tready;

    npcs_pal_ram u_pal_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (PAL_AW'(s_tdata[7:0])),
        .wdata (s_color),
        .raddr (scan_idx_reg[PAL_AW-1:0]),
        .rdata (ram_rdata)
    );

    npcs_dist_unit u_dist (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .query    (query_reg),
        .entry    (ram_rdata),
        .tag_in   (tag_reg),
        .cand_out (cand)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_idx_next   = scan_idx_reg;
        tag_next        = '0;
        found_next      = found_reg;
        best_dist_next  = best_dist_reg;
        best_idx_next   = best_idx_reg;
        best_color_next = best_color_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_found_next    = m_found_reg;

        // keep the first strictly smaller distance, so ties go to the lowest index
        if (cand.tag.valid && (!found_reg || cand.distance < best_dist_reg)) begin
            found_next      = 1'b1;
            best_dist_next  = cand.distance;
            best_idx_next   = cand.tag.index;
            best_color_next = cand.color;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_accept && s_tuser == OP_QUERY) begin
                    found_next    = 1'b0;
                    count_next    = count_eff;
                    scan_idx_next = '0;
                    state_next    = (count_eff == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                tag_next.valid = !(skip_en_reg && 32'(scan_idx_reg) == 32'(skip_idx_reg));
                tag_next.last  = (scan_idx_reg == CNT_W'(count_reg - CNT_W'(1)));
                tag_next.index = scan_idx_reg[PAL_AW-1:0];
                scan_idx_next  = CNT_W'(scan_idx_reg + CNT_W'(1));
                if (tag_next.last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (cand.tag.last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = found_reg;
                    if (found_reg) begin
                        m_data_next = {6'd0, best_dist_reg, best_color_reg, 8'(best_idx_reg)};
                    end else begin
                        m_data_next = {6'd0, DIST_MAX, 32'd0};
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            tag_reg     <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tag_reg     <= tag_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
        count_reg      <= count_next;
        scan_idx_reg   <= scan_idx_next;
        best_dist_reg  <= best_dist_next;
        best_idx_reg   <= best_idx_next;
        best_color_reg <= best_color_next;
        m_data_reg     <= m_data_next;
        m_found_reg    <= m_found_next;
        if (s_accept && s_tuser == OP_QUERY) begin
            query_reg <= s_color;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_found_reg;

    // candidates only come back while a scan is in flight
    a_cand_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cand.tag.valid |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("distance candidate outside a scan");

    // scan address stays inside the searched range
    a_scan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> scan_idx_reg < count_reg)
        else $error("scan index past count");

    // a found result carries a reachable distance
    a_found_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[49:32] <= DIST_REACH)
        else $error("found result with unreachable distance");

    // an empty search reports the saturated distance and zero index
    a_empty_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata[49:32] == DIST_MAX && m_tdata[31:0] == 32'd0))
        else $error("empty search result malformed");

    // the result is loaded only when the search has reached its end
    a_load_after_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result loaded before search finished");

endmodule : nearest_palette_color_search
`default_nettype wire

// ----- test/tb_nearest_palette_color_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search
// Self-checking bench for the palette nearest-color search. A queue of write
// and query requests feeds a bursty stream driver; every accepted query is
// predicted against a local palette copy and compared with the result stream,
// which is drained under random and long back-pressure. Registers are set
// between phases over apb and read back.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_search;
    import npcs_pkg::*;

    localparam logic [1:0] REG_UNMAPPED = 2'd3;  // slot past the register map
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 600;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 58;

    typedef struct packed {
        logic       op;
        logic [7:0] index;
        rgb_t       color;
    } pal_req_t;

    typedef struct packed {
        logic [7:0]        index;
        rgb_t              color;
        logic [DIST_W-1:0] distance;
        logic              found;
    } match_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // entry_index, red, green, blue
    logic        s_tuser = 1'b0; // op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // best_index, match_red, match_green, match_blue,
                                 // distance, zero pad
    logic        m_tuser;        // found
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    nearest_palette_color_search dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state, updated on accepted requests and register writes
    rgb_t             pal_mem [PAL_DEPTH];
    logic [CNT_W-1:0] cfg_count = 9'd256;
    logic             cfg_skip_en = 1'b0;
    logic [7:0]       cfg_skip_idx = 8'd0;

    // what the stimulus side has written so far, in request order
    rgb_t gen_pal [PAL_DEPTH];

    pal_req_t pending_reqs[$];
    match_t   awaited_matches[$];
    int       mismatches = 0;
    bit       s_fire = 1'b0;
    int       hold_requests = 0;

    function automatic rgb_t make_rgb(int r, int g, int b);
        return {8'(b), 8'(g), 8'(r)};
    endfunction

    function automatic rgb_t rand_rgb();
        return 24'($urandom);
    endfunction

    function automatic match_t nearest_entry(rgb_t q);
        match_t res;
        int span, dr, dg, db, d, best_d, best;
        bit hit;
        span = (cfg_count > PAL_DEPTH) ? PAL_DEPTH : int'(cfg_count);
        hit = 1'b0;
        best = 0;
        best_d = 0;
        for (int n = 0; n < span; n++) begin
            if (!(cfg_skip_en && n == int'(cfg_skip_idx))) begin
                dr = int'(q.red) - int'(pal_mem[n].red);
                dg = int'(q.green) - int'(pal_mem[n].green);
                db = int'(q.blue) - int'(pal_mem[n].blue);
                d = dr * dr + dg * dg + db * db;
                // strict less keeps the lowest index on a tie
                if (!hit || d < best_d) begin
                    hit = 1'b1;
                    best = n;
                    best_d = d;
                end
            end
        end
        res = '0;
        res.distance = DIST_MAX;
        if (hit) begin
            res.index = 8'(best);
            res.color = pal_mem[best];
            res.distance = DIST_W'(best_d);
            res.found = 1'b1;
        end
        return res;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        pal_req_t acc;
        match_t   got;
        match_t   want;
        s_fire = aresetn && s_tvalid && s_tready;
        if (s_fire) begin
            acc.op = s_tuser;
            acc.index = s_tdata[7:0];
            acc.color = s_tdata[31:8];
            if (acc.op == OP_WRITE) begin
                pal_mem[acc.index] = acc.color;
            end else begin
                awaited_matches.push_back(nearest_entry(acc.color));
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.index = m_tdata[7:0];
            got.color = m_tdata[31:8];
            got.distance = m_tdata[32 +: DIST_W];
            got.found = m_tuser;
            if (awaited_matches.size() == 0) begin
                $error("result arrived with no query outstanding");
                mismatches++;
            end else begin
                want = awaited_matches.pop_front();
                check_field("best_index", want.index, got.index);
                check_field("match_red", want.color.red, got.color.red);
                check_field("match_green", want.color.green, got.color.green);
                check_field("match_blue", want.color.blue, got.color.blue);
                check_field("distance", want.distance, got.distance);
                check_field("found", want.found, got.found);
            end
        end
    end

    int burst_left = 1;
    int gap_left = 0;

    always @(negedge aclk) begin : request_driver
        pal_req_t nxt;
        logic     next_valid;
        next_valid = s_tvalid && !s_fire;
        if (aresetn && !next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                s_tdata <= {nxt.color, nxt.index};
                s_tuser <= nxt.op;
                next_valid = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                             : $urandom_range(1, 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        s_tvalid <= next_valid;
    end

    int       hold_left = 0;
    int       holds_done = 0;
    int       mode_left = 0;
    bit [7:0] ready_mask = 8'hFF;

    always @(negedge aclk) begin : result_receiver
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(16, 96);
                ready_mask = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
            end
            mode_left--;
            ready_mask = {ready_mask[6:0], ready_mask[7]};
            m_tready <= ready_mask[0];
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        logic [31:0] keep;
        @(negedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PALETTE_COUNT: begin
                cfg_count = val[8:0];
                keep = 32'h1FF;
            end
            REG_SKIP_ENABLE: begin
                cfg_skip_en = val[0];
                keep = 32'h1;
            end
            REG_SKIP_INDEX: begin
                cfg_skip_idx = val[7:0];
                keep = 32'hFF;
            end
            default: keep = '0;
        endcase
        if (keep != '0) begin
            @(negedge aclk);
            psel <= 1'b1;
            pwrite <= 1'b0;
            @(negedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            if ((prdata & keep) != (val & keep)) begin
                $error("register %0d: expected %0d, got %0d", idx, val & keep, prdata & keep);
                mismatches++;
            end
            @(negedge aclk);
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic configure(int count, int skip_en, int skip_idx);
        reg_write(REG_PALETTE_COUNT, 32'(count));
        reg_write(REG_SKIP_ENABLE, 32'(skip_en));
        reg_write(REG_SKIP_INDEX, 32'(skip_idx));
    endtask

    task automatic load_entry(int idx, rgb_t c);
        gen_pal[idx] = c;
        pending_reqs.push_back({OP_WRITE, 8'(idx), c});
    endtask

    task automatic ask_nearest(rgb_t c);
        pending_reqs.push_back({OP_QUERY, 8'($urandom), c});
    endtask

    // wait until every request is taken and every result is back
    task automatic drain(int settle);
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || s_tvalid || awaited_matches.size() != 0);
        repeat (settle) @(posedge aclk);
    endtask

    // whole palette is written by now, so any index may be searched
    task automatic random_request(int span);
        rgb_t c;
        int   idx;
        if ($urandom_range(0, 9) < 7) begin
            case ($urandom_range(0, 9))
                0, 1: c = (span > 0) ? gen_pal[$urandom_range(0, span - 1)] : rand_rgb();
                2: c = make_rgb(255 * $urandom_range(0, 1), 255 * $urandom_range(0, 1),
                                255 * $urandom_range(0, 1));
                default: c = rand_rgb();
            endcase
            ask_nearest(c);
        end else begin
            idx = ($urandom_range(0, 1) == 1 && span > 0) ? $urandom_range(0, span - 1)
                                                          : $urandom_range(0, 255);
            c = ($urandom_range(0, 4) == 0) ? gen_pal[$urandom_range(0, 255)] : rand_rgb();
            load_entry(idx, c);
        end
    endtask

    initial begin : stimulus
        int count;
        int span;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // small palette with a duplicate color to force ties
        configure(4, 0, 0);
        load_entry(0, make_rgb(0, 0, 0));
        load_entry(1, make_rgb(255, 255, 255));
        load_entry(2, make_rgb(0, 0, 0));
        load_entry(3, make_rgb(255, 0, 128));
        load_entry(255, make_rgb(255, 255, 255));
        ask_nearest(make_rgb(0, 0, 0));
        ask_nearest(make_rgb(255, 255, 255));
        ask_nearest(make_rgb(250, 5, 120));
        ask_nearest(make_rgb(128, 128, 128));
        ask_nearest(make_rgb(0, 255, 0));
        drain(SETTLE_CYCLES);

        // transparent index on the tie winner moves the answer to its twin
        configure(4, 1, 0);
        ask_nearest(make_rgb(0, 0, 0));
        ask_nearest(make_rgb(10, 10, 10));
        drain(SETTLE_CYCLES);

        // transparent index outside the searched range
        configure(4, 1, 200);
        ask_nearest(make_rgb(0, 0, 0));
        drain(SETTLE_CYCLES);

        // single entry: largest reachable distance
        configure(1, 0, 0);
        ask_nearest(make_rgb(255, 255, 255));
        drain(SETTLE_CYCLES);

        // only entry skipped, then an empty search
        configure(1, 1, 0);
        ask_nearest(make_rgb(255, 255, 255));
        drain(SETTLE_CYCLES);
        configure(0, 0, 0);
        reg_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        ask_nearest(make_rgb(1, 2, 3));
        drain(SETTLE_CYCLES);

        // fill the whole palette before searching it all
        configure(256, 0, 0);
        for (int i = 0; i < PAL_DEPTH; i++) begin
            load_entry(i, (i > 0 && $urandom_range(0, 4) == 0) ? gen_pal[$urandom_range(0, i - 1)]
                                                               : rand_rgb());
        end
        repeat (8) random_request(PAL_DEPTH);
        drain(SETTLE_CYCLES);

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: count = 256;
                1: count = 511;
                default: count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 32);
            endcase
            span = (count > PAL_DEPTH) ? PAL_DEPTH : count;
            if (p == 0) begin
                configure(count, 1, 255);
            end else begin
                configure(count, $urandom_range(0, 1),
                          ($urandom_range(0, 1) == 1 && span > 0) ? $urandom_range(0, span - 1)
                                                                  : $urandom_range(0, 255));
            end
            // receiver goes quiet while requests keep coming
            if (p == 2) hold_requests++;
            repeat (PHASE_ITEMS) random_request(span);
            drain(SETTLE_CYCLES);
        end

        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- nearest_palette_color_search.f -----
rtl/npcs_pkg.sv
rtl/npcs_pal_ram.sv
rtl/npcs_dist_unit.sv
rtl/nearest_palette_color_search.sv
test/tb_nearest_palette_color_search.sv
